>>> rtl/kld_pkg.sv
package kld_pkg;

    localparam int TickW = 32;
    localparam int SeqW  = 32;
    localparam int KeyW  = 3;

    localparam logic [3:0]  ThrReset  = 4'd3;
    localparam logic [15:0] LongReset = 16'd500;
    localparam logic [15:0] RepReset  = 16'd200;
    localparam logic [35:0] PosReset  = 36'd58884833312;

    typedef enum logic [1:0] {
        CFG_THR  = 2'd0,
        CFG_LONG = 2'd1,
        CFG_REP  = 2'd2,
        CFG_POS  = 2'd3
    } t_cfg;

    typedef enum logic [2:0] {
        KIND_PRESS   = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_SHORT   = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_REPEAT  = 3'd4
    } t_kind;

    // event group raised by one key in one poll
    typedef enum logic [2:0] {
        GRP_NONE = 3'd0,
        GRP_PL   = 3'd1,   // press, long
        GRP_RP   = 3'd2,   // repeat
        GRP_PSR  = 3'd3,   // press, short, release
        GRP_RL   = 3'd4    // release after long
    } t_grp;

    function automatic logic [1:0] grp_len(input t_grp g);
        logic [1:0] len;
        case (g)
            GRP_PL:  len = 2'd2;
            GRP_RP:  len = 2'd1;
            GRP_PSR: len = 2'd3;
            GRP_RL:  len = 2'd1;
            default: len = 2'd0;
        endcase
        return len;
    endfunction

    function automatic logic grp_bump(input t_grp g);
        return (g == GRP_PL) || (g == GRP_PSR);
    endfunction

    function automatic t_kind grp_kind(input t_grp g, input logic [1:0] sub);
        t_kind kd;
        kd = KIND_PRESS;
        case (g)
            GRP_PL:  kd = (sub == 2'd0) ? KIND_PRESS : KIND_LONG;
            GRP_RP:  kd = KIND_REPEAT;
            GRP_PSR: begin
                case (sub)
                    2'd0:    kd = KIND_PRESS;
                    2'd1:    kd = KIND_SHORT;
                    default: kd = KIND_RELEASE;
                endcase
            end
            GRP_RL:  kd = KIND_RELEASE;
            default: kd = KIND_PRESS;
        endcase
        return kd;
    endfunction

endpackage

>>> rtl/keypad_debounce_long_repeat.sv
// Channel | Direction | Handshake                 | Payload
// poll    | in        | i_in_valid / o_in_stall   | i_now_tick, i_matrix_bits
// event   | out       | o_out_valid / i_out_stall | o_key_index, o_event_kind,
//         |           |                           | o_sequence_number, o_last_of_poll
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A poll is taken as a whole: all key lanes update together and the poll's
// events are latched into an event record. Events leave one per cycle from the
// record through an output register while the output is not stalled, at most 3
// per key of a poll; a poll without events leaves the record free for the next poll.
// The next poll is taken in the cycle the last event of the current one moves out.
// Reset clears configuration to its defaults, all key state and the sequence.
// An output stall holds the output register, then the record, then the poll input.
module keypad_debounce_long_repeat
    import kld_pkg::*;
#(
    parameter int NUM_KEYS = 6,
    parameter int NUM_ROWS = 8,
    parameter int NUM_COLS = 7
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_in_valid,
    output logic                                              o_in_stall,
    input  logic [TickW-1:0]                                  i_now_tick,
    input  logic [NUM_ROWS*NUM_COLS-1:0]                      i_matrix_bits,
    output logic                                              o_out_valid,
    input  logic                                              i_out_stall,
    output logic [KeyW-1:0]                                   o_key_index,
    output logic [2:0]                                        o_event_kind,
    output logic [SeqW-1:0]                                   o_sequence_number,
    output logic                                              o_last_of_poll,
    input  logic                                              i_cfg_valid,
    output logic                                              o_cfg_ready,
    input  logic [1:0]                                        i_cfg_index,
    input  logic [((6*NUM_KEYS > 16) ? 6*NUM_KEYS : 16)-1:0] i_cfg_data
);

    localparam int PosW = 6 * NUM_KEYS;

    logic       accept;
    logic       in_ready;
    t_grp       grp [NUM_KEYS];

    logic [3:0]      r_thr;
    logic [15:0]     r_long;
    logic [15:0]     r_rep;
    logic [PosW-1:0] r_pos;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !in_ready;
    assign accept      = i_in_valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= ThrReset;
            r_long <= LongReset;
            r_rep  <= RepReset;
            r_pos  <= PosW'(PosReset);
        end else if (i_cfg_valid) begin
            case (t_cfg'(i_cfg_index))
                CFG_THR:  r_thr  <= i_cfg_data[3:0];
                CFG_LONG: r_long <= i_cfg_data[15:0];
                CFG_REP:  r_rep  <= i_cfg_data[15:0];
                CFG_POS:  r_pos  <= i_cfg_data[PosW-1:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        kld_lane #(
            .NUM_ROWS (NUM_ROWS),
            .NUM_COLS (NUM_COLS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (accept),
            .i_pos    (r_pos[6*k +: 6]),
            .i_matrix (i_matrix_bits),
            .i_now    (i_now_tick),
            .i_thr    (r_thr),
            .i_long   (r_long),
            .i_rep    (r_rep),
            .o_grp    (grp[k])
        );
    end

    kld_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_grp             (grp),
        .o_in_ready        (in_ready),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_key_index       (o_key_index),
        .o_event_kind      (o_event_kind),
        .o_sequence_number (o_sequence_number),
        .o_last_of_poll    (o_last_of_poll)
    );

endmodule

>>> rtl/kld_lane.sv
module kld_lane
    import kld_pkg::*;
#(
    parameter int NUM_ROWS = 8,
    parameter int NUM_COLS = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [5:0]                   i_pos,
    input  logic [NUM_ROWS*NUM_COLS-1:0] i_matrix,
    input  logic [TickW-1:0]             i_now,
    input  logic [3:0]                   i_thr,
    input  logic [15:0]                  i_long,
    input  logic [15:0]                  i_rep,
    output t_grp                         o_grp
);

    logic [2:0]                   row;
    logic [2:0]                   col;
    logic                         in_range;
    logic [5:0]                   bit_idx;
    logic [NUM_ROWS*NUM_COLS-1:0] shifted;
    logic                         raw;
    logic [TickW-1:0]             held;
    logic [TickW-1:0]             since;

    logic             r_raw, n_raw;
    logic             r_level, n_level;
    logic [3:0]       r_cnt, n_cnt;
    logic [TickW-1:0] r_start, n_start;
    logic             r_lr, n_lr;
    logic [TickW-1:0] r_rpt, n_rpt;

    assign row      = i_pos[5:3];
    assign col      = i_pos[2:0];
    assign in_range = (32'(row) < NUM_ROWS) && (32'(col) < NUM_COLS);
    assign bit_idx  = 6'(32'(row) * NUM_COLS + 32'(col));
    assign shifted  = i_matrix >> bit_idx;
    assign raw      = in_range & shifted[0];
    assign held     = i_now - r_start;
    assign since    = i_now - r_rpt;

    always_comb begin
        n_raw   = r_raw;
        n_level = r_level;
        n_cnt   = r_cnt;
        n_start = r_start;
        n_lr    = r_lr;
        n_rpt   = r_rpt;
        o_grp   = GRP_NONE;

        if (raw == r_raw) begin
            if (r_cnt < i_thr) n_cnt = r_cnt + 4'd1;
        end else begin
            n_raw = raw;
            n_cnt = 4'd1;
        end

        if (n_cnt >= i_thr) begin
            if (r_level == n_raw) begin
                if (r_level) begin
                    if (!r_lr && held >= {16'd0, i_long}) begin
                        n_lr  = 1'b1;
                        n_rpt = i_now;
                        o_grp = GRP_PL;
                    end else if (r_lr && since >= {16'd0, i_rep}) begin
                        n_rpt = i_now;
                        o_grp = GRP_RP;
                    end
                end
            end else begin
                n_level = n_raw;
                if (n_raw) begin
                    n_start = i_now;
                    n_lr    = 1'b0;
                end else if (!r_lr) begin
                    o_grp = GRP_PSR;
                end else begin
                    o_grp = GRP_RL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= 1'b0;
            r_level <= 1'b0;
            r_cnt   <= ThrReset;
            r_start <= '0;
            r_lr    <= 1'b0;
            r_rpt   <= '0;
        end else if (i_accept) begin
            r_raw   <= n_raw;
            r_level <= n_level;
            r_cnt   <= n_cnt;
            r_start <= n_start;
            r_lr    <= n_lr;
            r_rpt   <= n_rpt;
        end
    end

endmodule

>>> rtl/kld_merge.sv
module kld_merge
    import kld_pkg::*;
#(
    parameter int NUM_KEYS = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  t_grp            i_grp [NUM_KEYS],
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [KeyW-1:0] o_key_index,
    output logic [2:0]      o_event_kind,
    output logic [SeqW-1:0] o_sequence_number,
    output logic            o_last_of_poll
);

    logic [3:0]          bump_acc;
    logic [SeqW-1:0]     lane_seq [NUM_KEYS];
    logic [NUM_KEYS-1:0] ev_mask;
    logic [NUM_KEYS-1:0] cur_oh;
    logic [NUM_KEYS-1:0] rest;
    t_grp                cur_grp;
    logic [SeqW-1:0]     cur_seq;
    logic [KeyW-1:0]     cur_key;
    logic                grp_last;
    logic                poll_last;
    logic                move;
    logic                load;

    t_grp                r_grp  [NUM_KEYS];
    logic [SeqW-1:0]     r_seqv [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_pend;
    logic [1:0]          r_sub;
    logic [SeqW-1:0]     r_seq;
    logic                r_ov;
    logic [KeyW-1:0]     r_key;
    t_kind               r_kind;
    logic [SeqW-1:0]     r_seqo;
    logic                r_last;

    // running sequence per lane: each lane sees bumps of itself and lower keys
    always_comb begin
        bump_acc = 4'd0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            bump_acc    = bump_acc + {3'd0, grp_bump(i_grp[k])};
            lane_seq[k] = r_seq + SeqW'(bump_acc);
            ev_mask[k]  = (i_grp[k] != GRP_NONE);
        end
    end

    // lowest pending lane goes first
    always_comb begin
        logic found;
        found   = 1'b0;
        cur_grp = GRP_NONE;
        cur_seq = '0;
        cur_key = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            cur_oh[k] = r_pend[k] & ~found;
            found     = found | r_pend[k];
            if (cur_oh[k]) begin
                cur_grp = r_grp[k];
                cur_seq = r_seqv[k];
                cur_key = KeyW'(k);
            end
        end
    end

    assign rest       = r_pend & ~cur_oh;
    assign grp_last   = (r_sub == grp_len(cur_grp) - 2'd1);
    assign poll_last  = grp_last && (rest == '0);
    assign move       = (r_pend != '0) && (!r_ov || !i_out_stall);
    assign o_in_ready = (r_pend == '0) || (move && poll_last);
    assign load       = i_accept && (ev_mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_sub  <= 2'd0;
            r_seq  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_accept) r_seq <= r_seq + SeqW'(bump_acc);

            if (move) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            if (load) begin
                r_pend <= ev_mask;
                r_sub  <= 2'd0;
            end else if (move) begin
                if (grp_last) begin
                    r_pend <= rest;
                    r_sub  <= 2'd0;
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_grp[k]  <= i_grp[k];
                r_seqv[k] <= lane_seq[k];
            end
        end
        if (move) begin
            r_key  <= cur_key;
            r_kind <= grp_kind(cur_grp, r_sub);
            r_seqo <= cur_seq;
            r_last <= poll_last;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_key_index       = r_key;
    assign o_event_kind      = r_kind;
    assign o_sequence_number = r_seqo;
    assign o_last_of_poll    = r_last;

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != '0) |-> (r_sub < grp_len(cur_grp)))
        else $error("event step beyond group length");

    a_load_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_pend != '0))
        else $error("poll with events left nothing pending");

    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_ov)
        else $error("event moved but output register empty");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> ((r_seq - $past(r_seq)) <= SeqW'(NUM_KEYS)))
        else $error("sequence advanced by more than one per key");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall && (r_pend != '0)) |-> !o_in_ready)
        else $error("new poll taken while events still queued");

endmodule

>>> tb/kld_tb_pkg.sv
`timescale 1ns / 1ps

package kld_tb_pkg;
    import kld_pkg::*;

    localparam int KEYS = 6;
    localparam int COLS = 7;

    typedef struct packed {
        logic [2:0]  key;
        t_kind       kind;
        logic [31:0] seq;
        logic        last;
    } t_key_evt;

    // Tracks the debounce and press-timing state of every key and queues
    // the key events each accepted poll must produce.
    class key_event_tracker;
        logic [3:0]  thr;
        logic [15:0] long_t;
        logic [15:0] rep_t;
        logic [35:0] layout;

        logic        raw_seen  [KEYS];
        logic        level     [KEYS];
        logic [3:0]  stable    [KEYS];
        logic [31:0] press_at  [KEYS];
        logic        long_done [KEYS];
        logic [31:0] repeat_at [KEYS];
        logic [31:0] seq_cnt;

        t_key_evt    due_events[$];
        int unsigned errors;
        int unsigned matched;
        int unsigned most_in_poll;
        int unsigned kind_seen [5];

        function new();
            thr    = ThrReset;
            long_t = LongReset;
            rep_t  = RepReset;
            layout = PosReset;
            for (int k = 0; k < KEYS; k++) begin
                raw_seen[k]  = 1'b0;
                level[k]     = 1'b0;
                stable[k]    = ThrReset;
                press_at[k]  = '0;
                long_done[k] = 1'b0;
                repeat_at[k] = '0;
            end
            seq_cnt      = '0;
            errors       = 0;
            matched      = 0;
            most_in_poll = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void write_reg(t_cfg idx, logic [35:0] val);
            case (idx)
                CFG_THR:  thr    = val[3:0];
                CFG_LONG: long_t = val[15:0];
                CFG_REP:  rep_t  = val[15:0];
                CFG_POS:  layout = val;
                default: ;
            endcase
        endfunction

        function t_key_evt make_evt(int k, t_kind kd);
            t_key_evt e;
            e.key  = 3'(k);
            e.kind = kd;
            e.seq  = seq_cnt;
            e.last = 1'b0;
            return e;
        endfunction

        function void take_poll(logic [31:0] now, logic [55:0] matrix);
            t_key_evt    batch[$];
            t_key_evt    e;
            logic [5:0]  p;
            logic [31:0] held;
            logic        raw;
            for (int k = 0; k < KEYS; k++) begin
                p = layout[6*k +: 6];
                // column 7 lies outside the matrix and never reads pressed
                if (p[2:0] < 3'(COLS))
                    raw = matrix[int'(p[5:3]) * COLS + int'(p[2:0])];
                else
                    raw = 1'b0;

                if (raw == raw_seen[k]) begin
                    if (stable[k] < thr) stable[k]++;
                end else begin
                    raw_seen[k] = raw;
                    stable[k]   = 4'd1;
                end
                if (stable[k] < thr) continue;

                if (level[k] == raw_seen[k]) begin
                    if (level[k]) begin
                        held = now - press_at[k];
                        if (!long_done[k] && held >= 32'(long_t)) begin
                            long_done[k] = 1'b1;
                            repeat_at[k] = now;
                            seq_cnt++;
                            batch.push_back(make_evt(k, KIND_PRESS));
                            batch.push_back(make_evt(k, KIND_LONG));
                        end else if (long_done[k]) begin
                            held = now - repeat_at[k];
                            if (held >= 32'(rep_t)) begin
                                repeat_at[k] = now;
                                batch.push_back(make_evt(k, KIND_REPEAT));
                            end
                        end
                    end
                    continue;
                end

                level[k] = raw_seen[k];
                if (level[k]) begin
                    press_at[k]  = now;
                    long_done[k] = 1'b0;
                end else if (!long_done[k]) begin
                    seq_cnt++;
                    batch.push_back(make_evt(k, KIND_PRESS));
                    batch.push_back(make_evt(k, KIND_SHORT));
                    batch.push_back(make_evt(k, KIND_RELEASE));
                end else begin
                    batch.push_back(make_evt(k, KIND_RELEASE));
                end
            end

            foreach (batch[i]) begin
                e      = batch[i];
                e.last = (i == batch.size() - 1);
                due_events.push_back(e);
            end
            if (batch.size() > most_in_poll) most_in_poll = batch.size();
        endfunction

        function void check_event(t_key_evt got);
            t_key_evt want;
            if (due_events.size() == 0) begin
                $error("unexpected key event: key %0d kind %0d seq %0d last %0d",
                       got.key, got.kind, got.seq, got.last);
                errors++;
                return;
            end
            want = due_events.pop_front();
            if (got.key !== want.key) begin
                $error("key_index: expected %0d, actual %0d", want.key, got.key);
                errors++;
            end
            if (got.kind !== want.kind) begin
                $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.seq !== want.seq) begin
                $error("sequence_number: expected %0d, actual %0d", want.seq, got.seq);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_of_poll: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
            matched++;
            kind_seen[want.kind]++;
        endfunction

        function int outstanding();
            return due_events.size();
        endfunction

        function void check_drained();
            if (due_events.size() != 0) begin
                $error("%0d key events never arrived", due_events.size());
                errors++;
            end
        endfunction
    endclass

endpackage

>>> tb/tb_keypad_debounce_long_repeat.sv
`timescale 1ns / 1ps

module tb_keypad_debounce_long_repeat;
    import kld_pkg::*;
    import kld_tb_pkg::*;

    localparam int DRAIN       = 8;
    localparam int QUIET_LIMIT = 2000;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PATTERN
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_now_tick;
    logic [55:0] i_matrix_bits;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_key_index;
    logic [2:0]  o_event_kind;
    logic [31:0] o_sequence_number;
    logic        o_last_of_poll;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [35:0] i_cfg_data;

    key_event_tracker tracker = new();

    logic [35:0] layout;
    logic [31:0] tick_now;
    t_rx_mode    rx_mode;
    int          hold_off_len;
    int unsigned polls_sent;
    int unsigned settings_run;

    keypad_debounce_long_repeat dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_now_tick        (i_now_tick),
        .i_matrix_bits     (i_matrix_bits),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_key_index       (o_key_index),
        .o_event_kind      (o_event_kind),
        .o_sequence_number (o_sequence_number),
        .o_last_of_poll    (o_last_of_poll),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // matrix with the given keys pressed; noise lands only on bits no key uses
    function automatic logic [55:0] key_matrix(input logic [5:0] held, input bit noisy);
        logic [55:0] m;
        logic [55:0] mask;
        logic [63:0] r;
        logic [5:0]  p;
        m    = '0;
        mask = '0;
        r    = {$urandom(), $urandom()};
        for (int k = 0; k < KEYS; k++) begin
            p = layout[6*k +: 6];
            if (p[2:0] != 3'd7) begin
                mask[int'(p[5:3]) * COLS + int'(p[2:0])] = 1'b1;
                if (held[k]) m[int'(p[5:3]) * COLS + int'(p[2:0])] = 1'b1;
            end
        end
        if (noisy) m = m | (r[55:0] & ~mask);
        return m;
    endfunction

    function automatic logic [35:0] random_layout(input bit allow_dead);
        logic [35:0] p;
        for (int k = 0; k < KEYS; k++) begin
            p[6*k +: 6] = 6'($urandom_range(0, 63));
            if (!allow_dead && p[6*k+2 -: 3] == 3'd7) p[6*k +: 3] = 3'($urandom_range(0, 6));
        end
        return p;
    endfunction

    task automatic send_poll(input logic [31:0] now, input logic [55:0] m);
        i_in_valid    <= 1'b1;
        i_now_tick    <= now;
        i_matrix_bits <= m;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_poll(now, m);
        polls_sent++;
    endtask

    task automatic put_reg(input t_cfg idx, input logic [35:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, val);
    endtask

    task automatic program_regs(input logic [3:0] thr, input logic [15:0] lng,
                                input logic [15:0] rep, input logic [35:0] pos);
        put_reg(CFG_THR, 36'(thr));
        put_reg(CFG_LONG, 36'(lng));
        put_reg(CFG_REP, 36'(rep));
        put_reg(CFG_POS, pos);
        i_cfg_valid <= 1'b0;
        layout = pos;
        settings_run++;
    endtask

    // wait for every queued event, then give a trailing event-free poll time to retire
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // key 0: debounce, long press, one repeat, release after long
        send_poll(32'd0, key_matrix(6'h00, 1'b0));
        for (int t = 10; t <= 30; t += 10) send_poll(32'(t), key_matrix(6'h01, 1'b0));
        send_poll(32'd530, key_matrix(6'h01, 1'b0));
        send_poll(32'd730, key_matrix(6'h01, 1'b0));
        for (int t = 740; t <= 760; t += 10) send_poll(32'(t), key_matrix(6'h00, 1'b0));
        // key 1: short press
        for (int t = 800; t <= 820; t += 10) send_poll(32'(t), key_matrix(6'h02, 1'b0));
        for (int t = 830; t <= 850; t += 10) send_poll(32'(t), key_matrix(6'h00, 1'b0));
        settle();

        // no debounce, zero long and repeat times, all keys on one matrix bit
        program_regs(4'd0, 16'd0, 16'd0, 36'd0);
        send_poll(32'd1000, 56'd1);
        send_poll(32'd1000, 56'd1);
        send_poll(32'd1000, 56'd1);
        send_poll(32'd1001, 56'd0);
        send_poll(32'd1002, 56'd1);
        send_poll(32'd1003, 56'd0);
        settle();

        // every key parked in column 7: nothing can ever read pressed
        program_regs(4'd15, 16'hFFFF, 16'hFFFF, '1);
        send_poll(32'hFFFF_FFFF, '1);
        send_poll(32'd0, '0);
    endtask

    task automatic run_keys(input int n, input int unsigned step_max, input bit noisy,
                            input bit gaps);
        logic [5:0]  held;
        logic [55:0] m;
        logic [63:0] r;
        int          burst;
        int          k;
        held  = '0;
        burst = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                k       = $urandom_range(0, 5);
                held[k] = ~held[k];
            end
            m = key_matrix(held, noisy);
            // single-poll bounce on one key
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(0, 5);
                m = m ^ key_matrix(6'(1 << k), 1'b0);
            end
            if (noisy && $urandom_range(0, 4) == 0) begin
                r = {$urandom(), $urandom()};
                m = r[55:0];
            end
            if (noisy && $urandom_range(0, 19) == 0)
                tick_now = $urandom();
            else
                tick_now = tick_now + $urandom_range(0, step_max);
            send_poll(tick_now, m);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if (gaps && $urandom_range(0, 3) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end
    endtask

    // result side back-pressure
    initial begin : receiver
        int held_left;
        int beat;
        held_left = 0;
        beat      = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            beat++;
            if (held_left == 0 && hold_off_len != 0) begin
                held_left    = hold_off_len;
                hold_off_len = 0;
            end
            if (held_left != 0) begin
                held_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (rx_mode)
                    RX_LIGHT:   i_out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:   i_out_stall <= ($urandom_range(0, 1) == 0);
                    RX_PATTERN: i_out_stall <= ((beat % 9) < 4);
                    default:    i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_event('{key: o_key_index, kind: t_kind'(o_event_kind),
                                  seq: o_sequence_number, last: o_last_of_poll});
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_now_tick    <= '0;
        i_matrix_bits <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_THR;
        i_cfg_data    <= '0;
        layout        = PosReset;
        tick_now      = '0;
        rx_mode       = RX_FREE;
        hold_off_len  = 0;
        polls_sent    = 0;
        settings_run  = 1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        settle();
        program_regs(4'd3, 16'd40, 16'd15, random_layout(1'b0));
        rx_mode = RX_LIGHT;
        run_keys(70, 12, 1'b0, 1'b1);

        // receiver holds off long enough for the poll side to back up
        settle();
        program_regs(4'd1, 16'd0, 16'd0, random_layout(1'b1));
        rx_mode      = RX_HEAVY;
        hold_off_len = 400;
        run_keys(60, 5, 1'b1, 1'b0);

        settle();
        program_regs(4'd15, 16'd100, 16'd30, random_layout(1'b0));
        rx_mode = RX_PATTERN;
        run_keys(80, 15, 1'b0, 1'b1);

        // shared key position, long times, tick wrap
        settle();
        program_regs(4'd0, 16'hFFFF, 16'hFFFF, '0);
        tick_now = 32'hFFFF_F000;
        rx_mode  = RX_LIGHT;
        run_keys(60, 20000, 1'b1, 1'b1);

        settle();
        program_regs(4'd2, 16'd20, 16'd0, random_layout(1'b1));
        tick_now = 32'hFFFF_FFF0;
        rx_mode  = RX_HEAVY;
        run_keys(60, 8, 1'b0, 1'b1);

        settle();
        program_regs(4'd7, 16'd300, 16'd50, '1);
        rx_mode = RX_FREE;
        run_keys(20, 50, 1'b1, 1'b0);

        settle();
        program_regs(ThrReset, LongReset, RepReset, PosReset);
        rx_mode = RX_PATTERN;
        run_keys(55, 100, 1'b1, 1'b1);

        settle();
        tracker.check_drained();

        $display("Sent %0d polls, %0d register sets; %0d events matched, at most %0d per poll.",
                 polls_sent, settings_run, tracker.matched, tracker.most_in_poll);
        $display("Events by kind: press %0d, release %0d, short %0d, long %0d, repeat %0d.",
                 tracker.kind_seen[KIND_PRESS], tracker.kind_seen[KIND_RELEASE],
                 tracker.kind_seen[KIND_SHORT], tracker.kind_seen[KIND_LONG],
                 tracker.kind_seen[KIND_REPEAT]);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
